FILE: rtl/tvv_pkg.sv
// Shared constants, register map and types for the video core.
package tvv_pkg;

  // Bus operations carried in the input tuser
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam int REG_ADDR_W = 6;
  localparam int REG_DEPTH  = 1 << REG_ADDR_W;

  // Register map
  localparam logic [REG_ADDR_W-1:0] R_SYNC    = 6'h00;
  localparam logic [REG_ADDR_W-1:0] R_BLANK   = 6'h01;
  localparam logic [REG_ADDR_W-1:0] R_BEAMRST = 6'h03;
  localparam logic [REG_ADDR_W-1:0] R_COLP0   = 6'h06;
  localparam logic [REG_ADDR_W-1:0] R_COLP1   = 6'h07;
  localparam logic [REG_ADDR_W-1:0] R_COLPF   = 6'h08;
  localparam logic [REG_ADDR_W-1:0] R_COLBK   = 6'h09;
  localparam logic [REG_ADDR_W-1:0] R_PFCTL   = 6'h0A;
  localparam logic [REG_ADDR_W-1:0] R_PFA     = 6'h0D;
  localparam logic [REG_ADDR_W-1:0] R_PFB     = 6'h0E;
  localparam logic [REG_ADDR_W-1:0] R_PFC     = 6'h0F;
  localparam logic [REG_ADDR_W-1:0] R_POS0    = 6'h10;
  localparam logic [REG_ADDR_W-1:0] R_POS1    = 6'h11;
  localparam logic [REG_ADDR_W-1:0] R_GFX0    = 6'h1B;
  localparam logic [REG_ADDR_W-1:0] R_GFX1    = 6'h1C;
  localparam logic [REG_ADDR_W-1:0] R_MOT0    = 6'h20;
  localparam logic [REG_ADDR_W-1:0] R_MOT1    = 6'h21;
  localparam logic [REG_ADDR_W-1:0] R_MOVE    = 6'h2A;

  // Bit positions inside control registers
  localparam int SYNC_BIT    = 1;
  localparam int BLANK_BIT   = 7;
  localparam int REFLECT_BIT = 0;
  localparam int SCORE_BIT   = 1;

  localparam int COLOUR_W    = 7;
  localparam int PF_BITS     = 20;           // playfield bits per half line
  localparam int PF_PERIOD   = 2 * PF_BITS;  // repeat period in playfield bits
  localparam int SCORE_SPLIT = 80;           // score mode colour change column

  localparam int DEF_VISIBLE_WIDTH   = 160;
  localparam int DEF_VISIBLE_HEIGHT  = 192;
  localparam int DEF_CLOCKS_PER_LINE = 228;
  localparam int DEF_LINES_PER_FRAME = 262;

  // Copies of the register bits the renderer and motion logic look at
  typedef struct packed {
    logic                sync;
    logic                blank;
    logic [COLOUR_W-1:0] colp0;
    logic [COLOUR_W-1:0] colp1;
    logic [COLOUR_W-1:0] colpf;
    logic [COLOUR_W-1:0] colbk;
    logic                reflect;
    logic                score;
    logic [3:0]          pfa;
    logic [7:0]          pfb;
    logic [7:0]          pfc;
    logic [7:0]          gfx0;
    logic [7:0]          gfx1;
    logic [3:0]          mot0;
    logic [3:0]          mot1;
  } shadow_t;

  // Renderer outcome for the pixel under the beam
  typedef struct packed {
    logic                valid;
    logic [COLOUR_W-1:0] colour;
    logic                hit_pp;
    logic                hit_p0f;
    logic                hit_p1f;
  } pix_t;

endpackage

FILE: rtl/tvv_regfile.sv
// 64 x 8 bus register store with per-entry valid bits and registered read.
module tvv_regfile (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic                           rd_en,
  input  logic [tvv_pkg::REG_ADDR_W-1:0] addr,
  input  logic [7:0]                     wr_data,
  output logic [7:0]                     rd_data
);
  import tvv_pkg::*;

  logic [7:0]           mem [REG_DEPTH];
  logic [REG_DEPTH-1:0] written;
  logic [7:0]           rd_q;
  logic                 rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= written[addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : 8'd0;

endmodule

FILE: rtl/tvv_render.sv
// Pixel renderer: playfield lookup, player windows, priority and collisions.
module tvv_render #(
  parameter int VISIBLE_WIDTH  = tvv_pkg::DEF_VISIBLE_WIDTH,
  parameter int VISIBLE_HEIGHT = tvv_pkg::DEF_VISIBLE_HEIGHT
) (
  input  tvv_pkg::shadow_t regs,
  input  logic [7:0]       col,
  input  logic [8:0]       line,
  input  logic [7:0]       pos0,
  input  logic [7:0]       pos1,
  output tvv_pkg::pix_t    pix
);
  import tvv_pkg::*;

  logic                vis;
  logic [5:0]          quad;
  logic [5:0]          idx6;
  logic [4:0]          idx5;
  logic [PF_BITS-1:0]  pf_vec;
  logic                pf;
  logic [8:0]          d0;
  logic [8:0]          d1;
  logic                p0;
  logic                p1;
  logic [COLOUR_W-1:0] c;

  assign vis = !regs.sync && !regs.blank &&
               ({1'b0, line} < 10'(VISIBLE_HEIGHT)) &&
               ({1'b0, col} < 9'(VISIBLE_WIDTH));

  // each playfield bit spans four columns
  assign quad = col[7:2];
  assign idx6 = (quad >= 6'(PF_PERIOD)) ? quad - 6'(PF_PERIOD) : quad;

  always_comb begin
    if (idx6 >= 6'(PF_BITS)) begin
      idx5 = regs.reflect ? 5'(6'(PF_PERIOD - 1) - idx6) : 5'(idx6 - 6'(PF_BITS));
    end else begin
      idx5 = idx6[4:0];
    end
  end

  // first byte nibble, second byte reversed, third byte straight
  always_comb begin
    pf_vec[3:0]   = regs.pfa;
    for (int i = 0; i < 8; i++) begin
      pf_vec[4 + i] = regs.pfb[7 - i];
    end
    pf_vec[19:12] = regs.pfc;
  end

  assign pf = pf_vec[idx5];

  assign d0 = {1'b0, col} - {1'b0, pos0};
  assign d1 = {1'b0, col} - {1'b0, pos1};
  assign p0 = !d0[8] && (d0[7:3] == 5'd0) && regs.gfx0[3'd7 - d0[2:0]];
  assign p1 = !d1[8] && (d1[7:3] == 5'd0) && regs.gfx1[3'd7 - d1[2:0]];

  always_comb begin
    c = regs.colbk;
    if (pf) begin
      if (regs.score) begin
        c = (col < 8'(SCORE_SPLIT)) ? regs.colp0 : regs.colp1;
      end else begin
        c = regs.colpf;
      end
    end
    if (p0) begin
      c = regs.colp0;
    end
    if (p1) begin
      c = regs.colp1;
    end
  end

  assign pix.valid   = vis;
  assign pix.colour  = vis ? c : '0;
  assign pix.hit_pp  = vis && p0 && p1;
  assign pix.hit_p0f = vis && p0 && pf;
  assign pix.hit_p1f = vis && p1 && pf;

endmodule

FILE: rtl/tv_interface_video_core.sv
// Video core top level: input stage, register side effects, beam and result register.
//
//  channel | dir | tdata                          | tuser        | tlast
//  s_      | in  | address[15:0], data[23:16]     | op[1:0]      | -
//  m_      | out | read_data, x, y, colour, hits  | pixel_valid  | end_of_frame
//
// One item per cycle while m_ does not stall; each item passes the input stage
// (register store read) and then the result register (render and state update).
// Reset (rst, synchronous) clears the store valid bits, beam counters, player
// positions, collision latches and both pipeline stages.
// A stall on m_ holds the result register; the input stage keeps accepting
// until both stages are full.
module tv_interface_video_core #(
  parameter int VISIBLE_WIDTH   = tvv_pkg::DEF_VISIBLE_WIDTH,
  parameter int VISIBLE_HEIGHT  = tvv_pkg::DEF_VISIBLE_HEIGHT,
  parameter int CLOCKS_PER_LINE = tvv_pkg::DEF_CLOCKS_PER_LINE,
  parameter int LINES_PER_FRAME = tvv_pkg::DEF_LINES_PER_FRAME
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], pixel_x[15:8], pixel_y[23:16], pixel_colour[30:24],
  // hit_players[31], hit_p0_field[32], hit_p1_field[33], zero[39:34]
  output logic [39:0] m_tdata,
  output logic [0:0]  m_tuser,   // pixel_valid[0]
  output logic        m_tlast    // end_of_frame
);
  import tvv_pkg::*;

  logic                  accept;
  logic                  advance;

  logic                  s1_valid;
  logic [1:0]            s1_op;
  logic [REG_ADDR_W-1:0] s1_reg;
  logic [7:0]            s1_data;
  logic [7:0]            rf_rd;

  shadow_t               shadow, shadow_next;
  logic [7:0]            col, col_next;
  logic [7:0]            col_mod, col_mod_next;   // beam column modulo visible width
  logic [8:0]            line, line_next;
  logic [15:0]           frame_num, frame_num_next;
  logic [7:0]            pos0, pos0_next;
  logic [7:0]            pos1, pos1_next;
  logic [7:0]            pm0, pm0_next;           // positions modulo visible width
  logic [7:0]            pm1, pm1_next;
  logic [2:0]            hits, hits_next;
  pix_t                  pix;

  logic [7:0]            rd_next;
  logic                  pv_next;
  logic [7:0]            px_next;
  logic [7:0]            py_next;
  logic [COLOUR_W-1:0]   colour_next;
  logic                  eof_next;

  logic [7:0]            rd;
  logic                  pv;
  logic [7:0]            px;
  logic [7:0]            py;
  logic [COLOUR_W-1:0]   colour;
  logic                  eof;

  logic [8:0]            nc;
  logic [8:0]            nm;
  logic [9:0]            nl;

  function automatic logic [7:0] apply_motion(input logic [7:0] pm, input logic [3:0] mot);
    logic [9:0] v;
    v = {2'b00, pm} + {{6{mot[3]}}, mot};
    if (v[9]) begin
      apply_motion = 8'(v + 10'(VISIBLE_WIDTH));
    end else if (v >= 10'(VISIBLE_WIDTH)) begin
      apply_motion = 8'(v - 10'(VISIBLE_WIDTH));
    end else begin
      apply_motion = v[7:0];
    end
  endfunction

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  tvv_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (s_tuser == OP_WRITE)),
    .rd_en   (accept && (s_tuser == OP_READ)),
    .addr    (s_tdata[REG_ADDR_W-1:0]),
    .wr_data (s_tdata[23:16]),
    .rd_data (rf_rd)
  );

  tvv_render #(
    .VISIBLE_WIDTH  (VISIBLE_WIDTH),
    .VISIBLE_HEIGHT (VISIBLE_HEIGHT)
  ) u_render (
    .regs (shadow),
    .col  (col),
    .line (line),
    .pos0 (pos0),
    .pos1 (pos1),
    .pix  (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= s_tuser;
      s1_reg  <= s_tdata[REG_ADDR_W-1:0];
      s1_data <= s_tdata[23:16];
    end
  end

  assign nc = {1'b0, col} + 9'd1;
  assign nm = {1'b0, col_mod} + 9'd1;
  assign nl = {1'b0, line} + 10'd1;

  always_comb begin
    shadow_next    = shadow;
    col_next       = col;
    col_mod_next   = col_mod;
    line_next      = line;
    frame_num_next = frame_num;
    pos0_next      = pos0;
    pos1_next      = pos1;
    pm0_next       = pm0;
    pm1_next       = pm1;
    hits_next      = hits;
    rd_next        = 8'd0;
    pv_next        = 1'b0;
    px_next        = 8'd0;
    py_next        = 8'd0;
    colour_next    = '0;
    eof_next       = 1'b0;
    unique case (s1_op)
      OP_READ: begin
        rd_next = rf_rd;
      end
      OP_WRITE: begin
        unique case (s1_reg)
          R_SYNC:    shadow_next.sync    = s1_data[SYNC_BIT];
          R_BLANK:   shadow_next.blank   = s1_data[BLANK_BIT];
          R_COLP0:   shadow_next.colp0   = s1_data[COLOUR_W-1:0];
          R_COLP1:   shadow_next.colp1   = s1_data[COLOUR_W-1:0];
          R_COLPF:   shadow_next.colpf   = s1_data[COLOUR_W-1:0];
          R_COLBK:   shadow_next.colbk   = s1_data[COLOUR_W-1:0];
          R_PFCTL: begin
            shadow_next.reflect = s1_data[REFLECT_BIT];
            shadow_next.score   = s1_data[SCORE_BIT];
          end
          R_PFA:     shadow_next.pfa     = s1_data[7:4];
          R_PFB:     shadow_next.pfb     = s1_data;
          R_PFC:     shadow_next.pfc     = s1_data;
          R_GFX0:    shadow_next.gfx0    = s1_data;
          R_GFX1:    shadow_next.gfx1    = s1_data;
          R_MOT0:    shadow_next.mot0    = s1_data[3:0];
          R_MOT1:    shadow_next.mot1    = s1_data[3:0];
          R_BEAMRST: begin
            col_next     = 8'd0;
            col_mod_next = 8'd0;
          end
          R_POS0: begin
            pos0_next = col;
            pm0_next  = col_mod;
          end
          R_POS1: begin
            pos1_next = col;
            pm1_next  = col_mod;
          end
          R_MOVE: begin
            pos0_next = apply_motion(pm0, shadow.mot0);
            pm0_next  = apply_motion(pm0, shadow.mot0);
            pos1_next = apply_motion(pm1, shadow.mot1);
            pm1_next  = apply_motion(pm1, shadow.mot1);
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        hits_next   = hits | {pix.hit_p1f, pix.hit_p0f, pix.hit_pp};
        pv_next     = pix.valid;
        px_next     = pix.valid ? col : 8'd0;
        py_next     = pix.valid ? line[7:0] : 8'd0;
        colour_next = pix.colour;
        if (nc >= 9'(CLOCKS_PER_LINE)) begin
          col_next     = 8'd0;
          col_mod_next = 8'd0;
          if (nl >= 10'(LINES_PER_FRAME)) begin
            line_next      = 9'd0;
            frame_num_next = frame_num + 16'd1;
            eof_next       = 1'b1;
          end else begin
            line_next = nl[8:0];
          end
        end else begin
          col_next     = nc[7:0];
          col_mod_next = (nm == 9'(VISIBLE_WIDTH)) ? 8'd0 : nm[7:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow    <= '0;
      col       <= 8'd0;
      col_mod   <= 8'd0;
      line      <= 9'd0;
      frame_num <= 16'd0;
      pos0      <= 8'd0;
      pos1      <= 8'd0;
      pm0       <= 8'd0;
      pm1       <= 8'd0;
      hits      <= 3'd0;
    end else if (advance) begin
      shadow    <= shadow_next;
      col       <= col_next;
      col_mod   <= col_mod_next;
      line      <= line_next;
      frame_num <= frame_num_next;
      pos0      <= pos0_next;
      pos1      <= pos1_next;
      pm0       <= pm0_next;
      pm1       <= pm1_next;
      hits      <= hits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd     <= rd_next;
      pv     <= pv_next;
      px     <= px_next;
      py     <= py_next;
      colour <= colour_next;
      eof    <= eof_next;
    end
  end

  // latches are shown as they stand once the item is done
  assign m_tdata = {6'd0, hits, colour, py, px, rd};
  assign m_tuser = pv;
  assign m_tlast = eof;

endmodule

FILE: rtl/tvv_checker.sv
// Port-level checks for the video core, bound to the top level.
module tvv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  logic [2:0] pending;
  logic [2:0] seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
      seen    <= 3'd0;
    end else begin
      pending <= pending + {2'd0, s_tvalid && s_tready} - {2'd0, m_tvalid && m_tready};
      if (m_tvalid && m_tready) begin
        seen <= seen | m_tdata[33:31];
      end
    end
  end

  // a result only follows an accepted input, and at most two are in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pending != 3'd0) && (pending <= 3'd2))
    else $error("result without pending input");

  // a drawn pixel never carries read data
  a_pixel_no_read: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
    else $error("pixel result carries read data");

  // collision latches only ever gain bits until reset
  a_sticky_hits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[33:31] & seen) == seen))
    else $error("collision latch dropped");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind tv_interface_video_core tvv_checker u_tvv_checker (.*);
